[rtl/core/slpt_pkg.sv]
// Shared types, constants and control store for the slew-limited position tracker.
package slpt_pkg;

    localparam int unsigned POS_W   = 17;
    localparam int unsigned VEL_W   = 21;
    localparam int unsigned DT_W    = 16;
    localparam int unsigned SIZE_W  = 17;
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned MS_W    = 24;
    localparam int unsigned AXES    = 4;
    localparam int unsigned AX_W    = 2;
    localparam int unsigned PC_W    = 4;
    localparam int unsigned Q_W     = 26;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned CFG_W   = 3;

    localparam logic [CNT_W-1:0]   DIV_STEPS    = 4'd13;
    localparam logic [POS_W-1:0]   ONE_Q16      = 17'd65536;
    localparam logic [POS_W-1:0]   POS_CENTER   = 17'd32768;
    localparam logic [SIZE_W-1:0]  SIZE_RESET   = 17'd13107;
    localparam logic [SPEED_W-1:0] SPEED_NORMAL = 16'd333;
    localparam logic [SPEED_W-1:0] SPEED_D1     = 16'd30720;
    localparam logic [SPEED_W-1:0] SPEED_D2     = 16'd35840;
    localparam logic [SPEED_W-1:0] SPEED_D3     = 16'd40960;
    localparam logic [POS_W-1:0]   ALPHA_NORMAL = 17'd36045;
    localparam logic [POS_W-1:0]   ALPHA_TOUCH  = 17'd65536;
    localparam logic [2*POS_W-1:0] ROUND_HALF   = 34'd32768;
    localparam logic [Q_W-1:0]     QPOS_LIMIT   = 26'd1048575;
    localparam logic [Q_W-1:0]     QNEG_LIMIT   = 26'd1048576;
    localparam logic signed [VEL_W-1:0] VEL_MAX = 21'h0FFFFF;
    localparam logic signed [VEL_W-1:0] VEL_MIN = 21'h100000;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_LEFT = 2'd1;
    localparam logic [1:0] MODE_BOTH = 2'd2;
    localparam logic [1:0] DIFF_D2   = 2'd2;
    localparam logic [1:0] DIFF_D3   = 2'd3;

    localparam logic [CFG_W-1:0] CFG_GAME_MODE    = 3'd0;
    localparam logic [CFG_W-1:0] CFG_DIFFICULTY   = 3'd1;
    localparam logic [CFG_W-1:0] CFG_LEFT_SIZE_Y  = 3'd2;
    localparam logic [CFG_W-1:0] CFG_LEFT_SIZE_Z  = 3'd3;
    localparam logic [CFG_W-1:0] CFG_RIGHT_SIZE_Y = 3'd4;
    localparam logic [CFG_W-1:0] CFG_RIGHT_SIZE_Z = 3'd5;

    // Step addresses of the control program.
    localparam logic [PC_W-1:0] PC_WAIT    = 4'd0;
    localparam logic [PC_W-1:0] PC_MSTEP   = 4'd1;
    localparam logic [PC_W-1:0] PC_CHECK   = 4'd2;
    localparam logic [PC_W-1:0] PC_DIFF    = 4'd3;
    localparam logic [PC_W-1:0] PC_SCALE   = 4'd4;
    localparam logic [PC_W-1:0] PC_CLAMP   = 4'd5;
    localparam logic [PC_W-1:0] PC_DIVLD   = 4'd6;
    localparam logic [PC_W-1:0] PC_DIVSTEP = 4'd7;
    localparam logic [PC_W-1:0] PC_WRITE   = 4'd8;
    localparam logic [PC_W-1:0] PC_NEXT    = 4'd9;
    localparam logic [PC_W-1:0] PC_EMIT    = 4'd10;
    localparam logic [PC_W-1:0] PC_RET     = 4'd11;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_MSTEP,
        OP_CHECK,
        OP_DIFF,
        OP_SCALE,
        OP_CLAMP,
        OP_DIVLD,
        OP_DIVSTEP,
        OP_WRITE,
        OP_NEXT,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NO_IN,
        CND_SKIP,
        CND_DIV_BUSY,
        CND_MORE,
        CND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic skip;
        logic div_busy;
        logic more_axes;
    } stat_t;

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            PC_WAIT:    w = '{op: OP_ACCEPT,  cond: CND_NO_IN,    target: PC_WAIT};
            PC_MSTEP:   w = '{op: OP_MSTEP,   cond: CND_NEVER,    target: PC_WAIT};
            PC_CHECK:   w = '{op: OP_CHECK,   cond: CND_SKIP,     target: PC_NEXT};
            PC_DIFF:    w = '{op: OP_DIFF,    cond: CND_NEVER,    target: PC_WAIT};
            PC_SCALE:   w = '{op: OP_SCALE,   cond: CND_NEVER,    target: PC_WAIT};
            PC_CLAMP:   w = '{op: OP_CLAMP,   cond: CND_NEVER,    target: PC_WAIT};
            PC_DIVLD:   w = '{op: OP_DIVLD,   cond: CND_NEVER,    target: PC_WAIT};
            PC_DIVSTEP: w = '{op: OP_DIVSTEP, cond: CND_DIV_BUSY, target: PC_DIVSTEP};
            PC_WRITE:   w = '{op: OP_WRITE,   cond: CND_NEVER,    target: PC_WAIT};
            PC_NEXT:    w = '{op: OP_NEXT,    cond: CND_MORE,     target: PC_CHECK};
            PC_EMIT:    w = '{op: OP_EMIT,    cond: CND_OUT_BUSY, target: PC_EMIT};
            PC_RET:     w = '{op: OP_NOP,     cond: CND_ALWAYS,   target: PC_WAIT};
            default:    w = '{op: OP_NOP,     cond: CND_ALWAYS,   target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

[rtl/core/slpt_in_if.sv]
// Input sample channel of the position tracker.
interface slpt_in_if import slpt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DT_W-1:0]  time_step;
    logic             touch_on;
    logic             left_active;
    logic [POS_W-1:0] left_target_y;
    logic [POS_W-1:0] left_target_z;
    logic             right_active;
    logic [POS_W-1:0] right_target_y;
    logic [POS_W-1:0] right_target_z;

    modport source (
        output valid, time_step, touch_on, left_active, left_target_y, left_target_z,
               right_active, right_target_y, right_target_z,
        input  ready
    );
    modport sink (
        input  valid, time_step, touch_on, left_active, left_target_y, left_target_z,
               right_active, right_target_y, right_target_z,
        output ready
    );
endinterface

[rtl/core/slpt_out_if.sv]
// Result channel of the position tracker.
interface slpt_out_if import slpt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [POS_W-1:0]        left_pos_y;
    logic [POS_W-1:0]        left_pos_z;
    logic signed [VEL_W-1:0] left_vel_y;
    logic signed [VEL_W-1:0] left_vel_z;
    logic [POS_W-1:0]        right_pos_y;
    logic [POS_W-1:0]        right_pos_z;
    logic signed [VEL_W-1:0] right_vel_y;
    logic signed [VEL_W-1:0] right_vel_z;

    modport source (
        output valid, left_pos_y, left_pos_z, left_vel_y, left_vel_z,
               right_pos_y, right_pos_z, right_vel_y, right_vel_z,
        input  ready
    );
    modport sink (
        input  valid, left_pos_y, left_pos_z, left_vel_y, left_vel_z,
               right_pos_y, right_pos_z, right_vel_y, right_vel_z,
        output ready
    );
endinterface

[rtl/core/slew_limited_position_tracker.sv]
// Each accepted input beat is processed axis by axis. A skipped axis only passes the
// check and next steps; a moving axis also runs the difference, scale, clamp, divider
// load, divider and write steps. The divider retires two quotient bits per cycle.
// The next beat is taken only after the last result is loaded, while that result waits.
// Reset: both trackers centered at 32768 with zero velocity, configuration registers
// at their defaults, no result pending.
module slew_limited_position_tracker import slpt_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    slpt_in_if.sink           sample,
    slpt_out_if.source        result,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_index,
    input  logic [SIZE_W-1:0] cfg_data
);

    logic [1:0]                  game_mode_reg;
    logic [1:0]                  difficulty_reg;
    logic [AXES-1:0][SIZE_W-1:0] size_reg;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [POS_W-1:0]            pos_out_reg [AXES];
    logic signed [VEL_W-1:0]     vel_out_reg [AXES];

    op_t                         op;
    stat_t                       stat;
    logic                        item_take;
    logic                        out_busy;
    logic                        out_load;
    logic                        skip;
    logic                        div_busy;
    logic                        more_axes;
    logic [POS_W-1:0]            pos [AXES];
    logic signed [VEL_W-1:0]     vel [AXES];

    assign sample.ready = (op == OP_ACCEPT);
    assign item_take    = sample.valid && sample.ready;
    assign out_busy     = out_valid_reg && !result.ready;
    assign out_load     = (op == OP_EMIT) && !out_busy;

    assign stat = '{in_valid: sample.valid, out_busy: out_busy, skip: skip,
                    div_busy: div_busy, more_axes: more_axes};

    slpt_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .op    (op)
    );

    slpt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .item_take    (item_take),
        .time_step    (sample.time_step),
        .touch_on     (sample.touch_on),
        .left_active  (sample.left_active),
        .right_active (sample.right_active),
        .target       ({sample.right_target_z, sample.right_target_y,
                        sample.left_target_z, sample.left_target_y}),
        .game_mode    (game_mode_reg),
        .difficulty   (difficulty_reg),
        .size         (size_reg),
        .pos          (pos),
        .vel          (vel),
        .skip         (skip),
        .div_busy     (div_busy),
        .more_axes    (more_axes)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            game_mode_reg  <= MODE_LEFT;
            difficulty_reg <= DIFF_D2;
            for (int i = 0; i < AXES; i++)
            begin
                size_reg[i] <= SIZE_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAME_MODE:    game_mode_reg  <= cfg_data[1:0];
                CFG_DIFFICULTY:   difficulty_reg <= cfg_data[1:0];
                CFG_LEFT_SIZE_Y:  size_reg[0]    <= cfg_data;
                CFG_LEFT_SIZE_Z:  size_reg[1]    <= cfg_data;
                CFG_RIGHT_SIZE_Y: size_reg[2]    <= cfg_data;
                CFG_RIGHT_SIZE_Z: size_reg[3]    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pos_out_reg <= pos;
            vel_out_reg <= vel;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.left_pos_y  = pos_out_reg[0];
    assign result.left_pos_z  = pos_out_reg[1];
    assign result.left_vel_y  = vel_out_reg[0];
    assign result.left_vel_z  = vel_out_reg[1];
    assign result.right_pos_y = pos_out_reg[2];
    assign result.right_pos_z = pos_out_reg[3];
    assign result.right_vel_y = vel_out_reg[2];
    assign result.right_vel_z = vel_out_reg[3];

    // A new beat is only taken in the wait step, never while a result is loaded.
    assert property (@(posedge clk) disable iff (!rst_n) item_take |-> !out_load)
        else $error("input beat taken while loading a result");

    assert property (@(posedge clk) disable iff (!rst_n) out_load |=> result.valid)
        else $error("loaded result not presented");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.left_pos_y <= ONE_Q16 && result.left_pos_z <= ONE_Q16 &&
                          result.right_pos_y <= ONE_Q16 && result.right_pos_z <= ONE_Q16))
        else $error("position outside unit range");

    // The divider must have finished before the velocity is written back.
    assert property (@(posedge clk) disable iff (!rst_n) (op == OP_WRITE) |-> !div_busy)
        else $error("velocity written before division finished");

endmodule

[rtl/core/slpt_seq.sv]
// Microcode sequencer: step counter, control store and conditional jumps.
module slpt_seq import slpt_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output op_t   op
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          word;
    logic            take;

    assign word = ucode(pc_reg);
    assign op   = word.op;

    always_comb
    begin
        case (word.cond)
            CND_NEVER:    take = 1'b0;
            CND_ALWAYS:   take = 1'b1;
            CND_NO_IN:    take = !stat.in_valid;
            CND_SKIP:     take = stat.skip;
            CND_DIV_BUSY: take = stat.div_busy;
            CND_MORE:     take = stat.more_axes;
            CND_OUT_BUSY: take = stat.out_busy;
            default:      take = 1'b0;
        endcase
        pc_next = take ? word.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[rtl/core/slpt_div.sv]
// Restoring divider that retires two quotient bits per cycle while step is held high.
module slpt_div import slpt_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             step,
    input  logic [Q_W-1:0]   dividend,
    input  logic [DT_W-1:0]  divisor,
    output logic [Q_W-1:0]   quotient,
    output logic             busy
);

    logic [Q_W-1:0]   acc_reg;
    logic [DT_W-1:0]  rem_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [DT_W:0]    s1;
    logic [DT_W:0]    s2;
    logic [DT_W:0]    r1;
    logic [DT_W:0]    r2;
    logic             ge1;
    logic             ge2;

    // The remainder stays below the divisor, so it always fits in DT_W bits.
    always_comb
    begin
        s1  = {rem_reg, acc_reg[Q_W-1]};
        ge1 = s1 >= {1'b0, divisor};
        r1  = ge1 ? s1 - {1'b0, divisor} : s1;
        s2  = {r1[DT_W-1:0], acc_reg[Q_W-2]};
        ge2 = s2 >= {1'b0, divisor};
        r2  = ge2 ? s2 - {1'b0, divisor} : s2;
    end

    // Busy drops in the cycle of the last step, and stays low once it is done.
    assign quotient = acc_reg;
    assign busy     = cnt_reg > CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
        end
        else if (step)
        begin
            acc_reg <= {acc_reg[Q_W-3:0], ge1, ge2};
            rem_reg <= r2[DT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= DIV_STEPS;
        end
        else if (step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

[rtl/core/slpt_dp.sv]
// Datapath: item registers, tracker state, slew limit, smoothing, clamp and velocity.
module slpt_dp import slpt_pkg::*; (
    input  logic                           clk,
    input  logic                           rst_n,
    input  op_t                            op,
    input  logic                           item_take,
    input  logic [DT_W-1:0]                time_step,
    input  logic                           touch_on,
    input  logic                           left_active,
    input  logic                           right_active,
    input  logic [AXES-1:0][POS_W-1:0]     target,
    input  logic [1:0]                     game_mode,
    input  logic [1:0]                     difficulty,
    input  logic [AXES-1:0][SIZE_W-1:0]    size,
    output logic [POS_W-1:0]               pos [AXES],
    output logic signed [VEL_W-1:0]        vel [AXES],
    output logic                           skip,
    output logic                           div_busy,
    output logic                           more_axes
);

    logic [DT_W-1:0]              dt_reg;
    logic                         touch_reg;
    logic [1:0]                   act_reg;
    logic [AXES-1:0][POS_W-1:0]   tgt_reg;
    logic [MS_W-1:0]              ms_reg;
    logic [POS_W-1:0]             dmag_reg;
    logic                         dneg_reg;
    logic [POS_W-1:0]             r_reg;
    logic [POS_W-1:0]             new_reg;
    logic                         vneg_reg;
    logic [AX_W-1:0]              axis_reg;
    logic [POS_W-1:0]             pos_reg [AXES];
    logic signed [VEL_W-1:0]      vel_reg [AXES];

    logic [SPEED_W-1:0]           speed;
    logic [POS_W-1:0]             alpha;
    logic [SPEED_W+DT_W-1:0]      ms_prod;
    logic                         trk;
    logic                         en;
    logic                         act;
    logic [POS_W-1:0]             cur_pos;
    logic [POS_W-1:0]             cur_tgt;
    logic [SIZE_W-1:0]            cur_size;
    logic [POS_W-1:0]             tclamp;
    logic                         diff_neg;
    logic [POS_W-1:0]             diff_mag;
    logic [POS_W-1:0]             lim_mag;
    logic [2*POS_W-1:0]           prod_rnd;
    logic [POS_W:0]               moved;
    logic [POS_W-1:0]             lo;
    logic [POS_W-1:0]             hi;
    logic [POS_W-1:0]             clamped;
    logic                         delta_neg;
    logic [POS_W-1:0]             delta_mag;
    logic [Q_W-1:0]               quotient;
    logic signed [VEL_W-1:0]      vel_sat;

    slpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (op == OP_DIVLD),
        .step     (op == OP_DIVSTEP),
        .dividend ({1'b0, delta_mag, 8'b0}),
        .divisor  (dt_reg),
        .quotient (quotient),
        .busy     (div_busy)
    );

    always_comb
    begin
        if (!touch_reg)
        begin
            speed = SPEED_NORMAL;
            alpha = ALPHA_NORMAL;
        end
        else
        begin
            alpha = ALPHA_TOUCH;
            if (difficulty == DIFF_D3)
            begin
                speed = SPEED_D3;
            end
            else if (difficulty == DIFF_D2)
            begin
                speed = SPEED_D2;
            end
            else
            begin
                speed = SPEED_D1;
            end
        end
        ms_prod = speed * dt_reg;

        // Axes 0 and 1 belong to the left tracker, 2 and 3 to the right one.
        trk       = axis_reg[AX_W-1];
        en        = trk ? (game_mode == MODE_BOTH) : (game_mode != MODE_NONE);
        act       = act_reg[trk];
        skip      = !(en && act && (dt_reg != '0));
        more_axes = axis_reg != AX_W'(AXES - 1);

        cur_pos  = pos_reg[axis_reg];
        cur_tgt  = tgt_reg[axis_reg];
        cur_size = size[axis_reg];

        tclamp   = (cur_tgt > ONE_Q16) ? ONE_Q16 : cur_tgt;
        diff_neg = tclamp < cur_pos;
        diff_mag = diff_neg ? cur_pos - tclamp : tclamp - cur_pos;
        lim_mag  = (MS_W'(diff_mag) > ms_reg) ? ms_reg[POS_W-1:0] : diff_mag;

        prod_rnd = dmag_reg * alpha + ROUND_HALF;

        // The smoothed step never overshoots the target, so this stays in range.
        moved = dneg_reg ? {1'b0, cur_pos} - {1'b0, r_reg} : {1'b0, cur_pos} + {1'b0, r_reg};
        lo    = {1'b0, cur_size[SIZE_W-1:1]};
        hi    = ONE_Q16 - lo;
        // Crossed range: values below lo clamp to lo, all others to hi.
        if (moved < {1'b0, lo})
        begin
            clamped = lo;
        end
        else if (moved > {1'b0, hi})
        begin
            clamped = hi;
        end
        else
        begin
            clamped = moved[POS_W-1:0];
        end

        delta_neg = new_reg < cur_pos;
        delta_mag = delta_neg ? cur_pos - new_reg : new_reg - cur_pos;

        if (vneg_reg)
        begin
            vel_sat = (quotient > QNEG_LIMIT) ? VEL_MIN : VEL_W'(~quotient[VEL_W-1:0] + 1'b1);
        end
        else
        begin
            vel_sat = (quotient > QPOS_LIMIT) ? VEL_MAX : quotient[VEL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            dt_reg    <= time_step;
            touch_reg <= touch_on;
            act_reg   <= {right_active, left_active};
            tgt_reg   <= target;
        end
        case (op)
            OP_MSTEP:
            begin
                ms_reg <= ms_prod[SPEED_W+DT_W-1:8];
            end
            OP_DIFF:
            begin
                dmag_reg <= lim_mag;
                dneg_reg <= diff_neg;
            end
            OP_SCALE:
            begin
                r_reg <= prod_rnd[POS_W+15:16];
            end
            OP_CLAMP:
            begin
                new_reg <= clamped;
            end
            OP_DIVLD:
            begin
                vneg_reg <= delta_neg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                pos_reg[i] <= POS_CENTER;
                vel_reg[i] <= '0;
            end
        end
        else
        begin
            case (op)
                OP_MSTEP:
                begin
                    axis_reg <= '0;
                end
                OP_CHECK:
                begin
                    if (en && !act)
                    begin
                        vel_reg[axis_reg] <= '0;
                    end
                end
                OP_WRITE:
                begin
                    pos_reg[axis_reg] <= new_reg;
                    vel_reg[axis_reg] <= vel_sat;
                end
                OP_NEXT:
                begin
                    axis_reg <= axis_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign pos = pos_reg;
    assign vel = vel_reg;

endmodule

[test/slew_limited_position_tracker_tb.sv]
// Self-checking testbench for the position tracker: directed, stall and random cases.
module slew_limited_position_tracker_tb import slpt_pkg::*; ();

    localparam logic [CFG_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [1:0] MODE_LEFT_ALIAS = 2'd3;
    localparam logic [1:0] DIFF_ZERO       = 2'd0;
    localparam logic [1:0] DIFF_D1         = 2'd1;
    localparam longint UNIT       = longint'(ONE_Q16);
    localparam longint VEL_TOP    = longint'(VEL_MAX);
    localparam longint VEL_BOTTOM = longint'(VEL_MIN);
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_SAMPLES  = 142;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLD_OFF       = 300;

    typedef struct {
        logic [DT_W-1:0]  dt;
        logic             touch;
        logic             left_on;
        logic [POS_W-1:0] ly;
        logic [POS_W-1:0] lz;
        logic             right_on;
        logic [POS_W-1:0] ry;
        logic [POS_W-1:0] rz;
    } sample_t;

    typedef struct {
        longint y;
        longint z;
        longint vy;
        longint vz;
    } tracker_state_t;

    typedef struct {
        tracker_state_t left;
        tracker_state_t right;
    } tracker_pair_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_index;
    logic [SIZE_W-1:0] cfg_data;

    slpt_in_if  sample_ch ();
    slpt_out_if result_ch ();

    slew_limited_position_tracker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted block state and register copies.
    logic [1:0]        model_mode;
    logic [1:0]        model_difficulty;
    logic [SIZE_W-1:0] model_left_size_y;
    logic [SIZE_W-1:0] model_left_size_z;
    logic [SIZE_W-1:0] model_right_size_y;
    logic [SIZE_W-1:0] model_right_size_z;
    tracker_pair_t     model_pos;
    tracker_pair_t     expected_states [$];
    logic [POS_W-1:0]  aim [4];

    int mismatch_count  = 0;
    int samples_sent    = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int hold_cycles     = 0;
    bit gaps_on         = 1'b1;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic longint scale_by_alpha(longint d, longint alpha);
        longint mag;
        longint r;
        mag = (d < 0) ? -d : d;
        r = (mag * alpha + 32768) >> 16;
        return (d < 0) ? -r : r;
    endfunction

    function automatic longint keep_inside(longint v, longint extent);
        longint half;
        half = extent >> 1;
        // Crossed range: values below half clamp to half, all others to UNIT - half.
        if (v < half)
            return half;
        if (v > UNIT - half)
            return UNIT - half;
        return v;
    endfunction

    function automatic longint speed_over(longint delta, longint dt);
        longint q;
        q = (((delta < 0) ? -delta : delta) << 8) / dt;
        if (delta < 0)
            q = -q;
        if (q > VEL_TOP)
            q = VEL_TOP;
        if (q < VEL_BOTTOM)
            q = VEL_BOTTOM;
        return q;
    endfunction

    function automatic longint slew_axis(longint pos, longint target, longint step_cap,
                                         longint alpha, longint extent);
        longint t;
        longint d;
        t = (target > UNIT) ? UNIT : target;
        d = t - pos;
        if (d > step_cap)
            d = step_cap;
        if (d < -step_cap)
            d = -step_cap;
        return keep_inside(pos + scale_by_alpha(d, alpha), extent);
    endfunction

    function automatic tracker_state_t chase_target(tracker_state_t p, longint ty, longint tz,
                                                    longint dt, longint speed, longint alpha,
                                                    longint sy, longint sz);
        tracker_state_t n;
        longint step_cap;
        n = p;
        if (dt == 0)
            return p;
        step_cap = (speed * dt) >> 8;
        n.y  = slew_axis(p.y, ty, step_cap, alpha, sy);
        n.z  = slew_axis(p.z, tz, step_cap, alpha, sz);
        n.vy = speed_over(n.y - p.y, dt);
        n.vz = speed_over(n.z - p.z, dt);
        return n;
    endfunction

    function automatic void advance_trackers(input sample_t s);
        longint speed;
        longint alpha;
        speed = longint'(SPEED_NORMAL);
        alpha = longint'(ALPHA_NORMAL);
        if (s.touch)
        begin
            alpha = longint'(ALPHA_TOUCH);
            if (model_difficulty == DIFF_D3)
                speed = longint'(SPEED_D3);
            else if (model_difficulty == DIFF_D2)
                speed = longint'(SPEED_D2);
            else
                speed = longint'(SPEED_D1);
        end
        if (model_mode != MODE_NONE)
        begin
            if (s.left_on)
                model_pos.left = chase_target(model_pos.left, longint'(s.ly), longint'(s.lz),
                                              longint'(s.dt), speed, alpha,
                                              longint'(model_left_size_y),
                                              longint'(model_left_size_z));
            else
            begin
                model_pos.left.vy = 0;
                model_pos.left.vz = 0;
            end
        end
        if (model_mode == MODE_BOTH)
        begin
            if (s.right_on)
                model_pos.right = chase_target(model_pos.right, longint'(s.ry), longint'(s.rz),
                                               longint'(s.dt), speed, alpha,
                                               longint'(model_right_size_y),
                                               longint'(model_right_size_z));
            else
            begin
                model_pos.right.vy = 0;
                model_pos.right.vz = 0;
            end
        end
        expected_states.push_back(model_pos);
    endfunction

    function automatic sample_t make_sample(logic [DT_W-1:0] dt, logic touch, logic left_on,
                                            logic [POS_W-1:0] ly, logic [POS_W-1:0] lz,
                                            logic right_on, logic [POS_W-1:0] ry,
                                            logic [POS_W-1:0] rz);
        sample_t s;
        s.dt       = dt;
        s.touch    = touch;
        s.left_on  = left_on;
        s.ly       = ly;
        s.lz       = lz;
        s.right_on = right_on;
        s.ry       = ry;
        s.rz       = rz;
        return s;
    endfunction

    function automatic logic [POS_W-1:0] pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return POS_W'($urandom_range(0, 131071));
        if (r < 11)
            return '0;
        if (r < 14)
            return ONE_Q16;
        return POS_W'($urandom_range(0, 65536));
    endfunction

    function automatic logic [DT_W-1:0] pick_time_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 9)
            return DT_W'($urandom_range(1, 15));
        if (r < 19)
            return DT_W'($urandom_range(0, 65535));
        return DT_W'($urandom_range(16, 4000));
    endfunction

    function automatic logic [SIZE_W-1:0] pick_extent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return ONE_Q16;
        if (r < 28)
            return SIZE_W'($urandom_range(65537, 131071));
        return SIZE_W'($urandom_range(0, 26214));
    endfunction

    // Most samples follow slowly changing targets so the trackers converge and hit
    // their edges; the rest are unrelated noise.
    function automatic sample_t random_sample();
        sample_t s;
        if ($urandom_range(0, 9) == 0)
            return make_sample(DT_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), POS_W'($urandom_range(0, 131071)),
                               POS_W'($urandom_range(0, 131071)), 1'($urandom_range(0, 1)),
                               POS_W'($urandom_range(0, 131071)),
                               POS_W'($urandom_range(0, 131071)));
        for (int i = 0; i < 4; i++)
            if ($urandom_range(0, 99) < 30)
                aim[i] = pick_target();
        s = make_sample(pick_time_step(), 1'($urandom_range(0, 1)), $urandom_range(0, 99) < 85,
                        aim[0], aim[1], $urandom_range(0, 99) < 85, aim[2], aim[3]);
        return s;
    endfunction

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [SIZE_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_GAME_MODE:    model_mode         = value[1:0];
            CFG_DIFFICULTY:   model_difficulty   = value[1:0];
            CFG_LEFT_SIZE_Y:  model_left_size_y  = value;
            CFG_LEFT_SIZE_Z:  model_left_size_z  = value;
            CFG_RIGHT_SIZE_Y: model_right_size_y = value;
            CFG_RIGHT_SIZE_Z: model_right_size_z = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic send_sample(input sample_t s);
        int gap;
        gap = gaps_on ? idle_length() : 0;
        if (gap > 0)
        begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid          = 1'b1;
        sample_ch.time_step      = s.dt;
        sample_ch.touch_on       = s.touch;
        sample_ch.left_active    = s.left_on;
        sample_ch.left_target_y  = s.ly;
        sample_ch.left_target_z  = s.lz;
        sample_ch.right_active   = s.right_on;
        sample_ch.right_target_y = s.ry;
        sample_ch.right_target_z = s.rz;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        advance_trackers(s);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        sample_ch.valid = 1'b0;
        while (expected_states.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        tracker_pair_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (expected_states.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, expected none, actual %0d",
                         $time, result_ch.left_pos_y);
                mismatch_count++;
            end
            else
            begin
                want = expected_states.pop_front();
                check_field("left_pos_y",  want.left.y,   longint'(result_ch.left_pos_y));
                check_field("left_pos_z",  want.left.z,   longint'(result_ch.left_pos_z));
                check_field("left_vel_y",  want.left.vy,  longint'(result_ch.left_vel_y));
                check_field("left_vel_z",  want.left.vz,  longint'(result_ch.left_vel_z));
                check_field("right_pos_y", want.right.y,  longint'(result_ch.right_pos_y));
                check_field("right_pos_z", want.right.z,  longint'(result_ch.right_pos_z));
                check_field("right_vel_y", want.right.vy, longint'(result_ch.right_vel_y));
                check_field("right_vel_z", want.right.vz, longint'(result_ch.right_vel_z));
                results_checked++;
            end
        end
    end

    // Result-side stalls; a requested hold-off takes priority over random ones.
    always
    begin
        result_ch.ready = 1'b1;
        @(negedge clk);
        if (hold_cycles > 0)
        begin
            result_ch.ready = 1'b0;
            repeat (hold_cycles) @(negedge clk);
            hold_cycles = 0;
        end
        else if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            result_ch.ready = 1'b0;
            repeat (idle_length() + 1) @(negedge clk);
        end
    end

    task automatic test_power_on_defaults();
        send_sample(make_sample(16'd0, 1'b0, 1'b1, '0, '0, 1'b0, '0, '0));
        send_sample(make_sample(16'hFFFF, 1'b0, 1'b1, 17'h1FFFF, '0, 1'b1, 17'h1FFFF,
                                17'h1FFFF));
        send_sample(make_sample(16'd100, 1'b1, 1'b1, '0, ONE_Q16, 1'b1, '0, '0));
        // A zero time step must keep the velocity left by the previous step.
        send_sample(make_sample(16'd0, 1'b1, 1'b1, '0, '0, 1'b0, '0, '0));
        send_sample(make_sample(16'd500, 1'b1, 1'b0, ONE_Q16, ONE_Q16, 1'b1, '0, '0));
        send_sample(make_sample(16'd1, 1'b1, 1'b1, 17'd40000, 17'd20000, 1'b0, '0, '0));
        drain_results();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_GAME_MODE, {15'h7FFF, MODE_BOTH});
        write_reg(CFG_DIFFICULTY, {15'h7FFF, DIFF_ZERO});
        write_reg(CFG_LEFT_SIZE_Y, '0);
        write_reg(CFG_LEFT_SIZE_Z, ONE_Q16);
        write_reg(CFG_RIGHT_SIZE_Y, 17'h1FFFF);
        write_reg(CFG_RIGHT_SIZE_Z, 17'd65538);
        write_reg(CFG_SPARE_LO, 17'h1FFFF);
        write_reg(CFG_SPARE_HI, 17'h15555);
        send_sample(make_sample(16'hFFFF, 1'b1, 1'b1, 17'h1FFFF, '0, 1'b1, '0, 17'h1FFFF));
        send_sample(make_sample(16'd1, 1'b1, 1'b1, '0, ONE_Q16, 1'b1, ONE_Q16, '0));
        send_sample(make_sample(16'd3000, 1'b0, 1'b1, 17'd20000, 17'd20000, 1'b1, 17'd50000,
                                17'd50000));
        drain_results();
        write_reg(CFG_DIFFICULTY, {15'h0000, DIFF_D3});
        send_sample(make_sample(16'd200, 1'b1, 1'b1, ONE_Q16, '0, 1'b1, '0, ONE_Q16));
        drain_results();
        write_reg(CFG_DIFFICULTY, {15'h2AAA, DIFF_D1});
        send_sample(make_sample(16'd200, 1'b1, 1'b1, '0, ONE_Q16, 1'b1, ONE_Q16, '0));
        drain_results();
        // Mode three drives the left tracker only.
        write_reg(CFG_GAME_MODE, {15'h7FFF, MODE_LEFT_ALIAS});
        send_sample(make_sample(16'd700, 1'b0, 1'b1, 17'd10000, 17'd60000, 1'b1, 17'd10000,
                                17'd10000));
        drain_results();
        write_reg(CFG_GAME_MODE, {15'h5555, MODE_NONE});
        send_sample(make_sample(16'd700, 1'b1, 1'b1, 17'd30000, 17'd30000, 1'b1, '0, '0));
        send_sample(make_sample(16'd700, 1'b1, 1'b0, '0, '0, 1'b0, '0, '0));
        drain_results();
    endtask

    task automatic test_velocity_saturation();
        write_reg(CFG_GAME_MODE, {15'h0000, MODE_BOTH});
        write_reg(CFG_LEFT_SIZE_Y, '0);
        write_reg(CFG_LEFT_SIZE_Z, '0);
        write_reg(CFG_RIGHT_SIZE_Y, '0);
        write_reg(CFG_RIGHT_SIZE_Z, '0);
        send_sample(make_sample(16'hFFFF, 1'b1, 1'b1, '0, 17'h1FFFF, 1'b1, 17'h1FFFF, '0));
        drain_results();
        // Growing the extent pulls the trackers from the edges to the center in one
        // tiny time step, far beyond the velocity range.
        write_reg(CFG_LEFT_SIZE_Y, ONE_Q16);
        write_reg(CFG_LEFT_SIZE_Z, ONE_Q16);
        write_reg(CFG_RIGHT_SIZE_Y, ONE_Q16);
        write_reg(CFG_RIGHT_SIZE_Z, ONE_Q16);
        send_sample(make_sample(16'd1, 1'b0, 1'b1, '0, 17'h1FFFF, 1'b1, 17'h1FFFF, '0));
        send_sample(make_sample(16'd1, 1'b0, 1'b0, '0, '0, 1'b1, '0, '0));
        drain_results();
    endtask

    task automatic test_output_backpressure();
        gaps_on     = 1'b0;
        hold_cycles = HOLD_OFF;
        repeat (12) send_sample(random_sample());
        gaps_on = 1'b1;
        drain_results();
    endtask

    task automatic test_random_tracking();
        int r;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            r = $urandom_range(0, 9);
            write_reg(CFG_GAME_MODE, {15'($urandom()),
                      (r == 0) ? MODE_NONE : (r == 1) ? MODE_LEFT :
                      (r == 2) ? MODE_LEFT_ALIAS : MODE_BOTH});
            write_reg(CFG_DIFFICULTY, {15'($urandom()), 2'($urandom_range(0, 3))});
            write_reg(CFG_LEFT_SIZE_Y, pick_extent());
            write_reg(CFG_LEFT_SIZE_Z, pick_extent());
            write_reg(CFG_RIGHT_SIZE_Y, pick_extent());
            write_reg(CFG_RIGHT_SIZE_Z, pick_extent());
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          SIZE_W'($urandom_range(0, 131071)));
            gaps_on = (phase % 4 != 1);
            repeat (PHASE_SAMPLES) send_sample(random_sample());
        end
        gaps_on = 1'b1;
        drain_results();
    endtask

    initial
    begin
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = '0;
        cfg_data                 = '0;
        sample_ch.valid          = 1'b0;
        sample_ch.time_step      = '0;
        sample_ch.touch_on       = 1'b0;
        sample_ch.left_active    = 1'b0;
        sample_ch.left_target_y  = '0;
        sample_ch.left_target_z  = '0;
        sample_ch.right_active   = 1'b0;
        sample_ch.right_target_y = '0;
        sample_ch.right_target_z = '0;
        model_mode               = MODE_LEFT;
        model_difficulty         = DIFF_D2;
        model_left_size_y        = SIZE_RESET;
        model_left_size_z        = SIZE_RESET;
        model_right_size_y       = SIZE_RESET;
        model_right_size_z       = SIZE_RESET;
        model_pos.left           = '{longint'(POS_CENTER), longint'(POS_CENTER), 0, 0};
        model_pos.right          = '{longint'(POS_CENTER), longint'(POS_CENTER), 0, 0};
        for (int i = 0; i < 4; i++)
            aim[i] = POS_CENTER;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_power_on_defaults();
        test_register_extremes();
        test_velocity_saturation();
        test_output_backpressure();
        test_random_tracking();

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d samples and checked %0d results over %0d register writes,",
                 samples_sent, results_checked, reg_writes);
        $display("including mode and difficulty extremes, crossed extents, a long stall.");
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Timed out with %0d results still expected", expected_states.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
